### rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int MAX_STEPS_DEF = 256;
  localparam int QUEUE_DEPTH   = 2;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FIRE  = 1'b1;

  // entry faces
  localparam logic [2:0] FACE_START = 3'd0;
  localparam logic [2:0] FACE_POS_X = 3'd1;
  localparam logic [2:0] FACE_NEG_X = 3'd2;
  localparam logic [2:0] FACE_POS_Y = 3'd3;
  localparam logic [2:0] FACE_NEG_Y = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;
  localparam logic [2:0] FACE_NEG_Z = 3'd6;

  // per-axis ray setup
  typedef struct packed {
    logic signed [7:0] base;   // floor of origin
    logic [8:0]        num;    // Q1.8 distance to first boundary
    logic [15:0]       mag;    // |dir|
    logic              neg;
    logic              zero;
  } axis_t;

  typedef struct packed {
    logic               action;
    logic [11:0]        word_address;
    logic [63:0]        word_bits;
    axis_t [2:0]        ax;
    logic signed [15:0] origin_y;
    logic [15:0]        ray_limit;
  } item_t;

endpackage

### rtl/vrt_ifs.sv
// ----------------------------------------------------------------------------
// vrt_cmd_if / vrt_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface vrt_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] word_address;
  logic [63:0] word_bits;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic signed [15:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [15:0] ray_limit;

  modport source (output valid, action, word_address, word_bits, origin_x, origin_y,
                  origin_z, dir_x, dir_y, dir_z, ray_limit, input ready);
  modport sink (input valid, action, word_address, word_bits, origin_x, origin_y,
                origin_z, dir_x, dir_y, dir_z, ray_limit, output ready);
endinterface

interface vrt_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [5:0] voxel_x;
  logic [5:0] voxel_y;
  logic [5:0] voxel_z;
  logic [2:0] entry_face;
  logic       upper_half;

  modport source (output valid, hit, voxel_x, voxel_y, voxel_z, entry_face, upper_half,
                  input ready);
  modport sink (input valid, hit, voxel_x, voxel_y, voxel_z, entry_face, upper_half,
                output ready);
endinterface

### rtl/vrt_front.sv
// ----------------------------------------------------------------------------
// vrt_front
// Accepts command words and classifies ray setup per axis.
// ----------------------------------------------------------------------------
module vrt_front (
  vrt_cmd_if.sink          cmd,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output vrt_pkg::item_t   item
);

  logic signed [15:0] org [3];
  logic signed [15:0] dir [3];

  assign org[0] = cmd.origin_x;
  assign org[1] = cmd.origin_y;
  assign org[2] = cmd.origin_z;
  assign dir[0] = cmd.dir_x;
  assign dir[1] = cmd.dir_y;
  assign dir[2] = cmd.dir_z;

  assign cmd.ready = !q_full && !clearing;
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    item.action       = cmd.action;
    item.word_address = cmd.word_address;
    item.word_bits    = cmd.word_bits;
    item.origin_y     = cmd.origin_y;
    item.ray_limit    = cmd.ray_limit;
    for (int k = 0; k < 3; k++) begin
      item.ax[k].base = org[k][15:8];
      item.ax[k].neg  = dir[k][15];
      item.ax[k].zero = (dir[k] == 16'sd0);
      item.ax[k].mag  = dir[k][15] ? 16'(-dir[k]) : 16'(dir[k]);
      // moving +: boundary ahead is 256 - frac; otherwise frac
      if (!dir[k][15] && dir[k] != 16'sd0) begin
        item.ax[k].num = 9'd256 - 9'(org[k][7:0]);
      end else begin
        item.ax[k].num = 9'(org[k][7:0]);
      end
    end
  end

endmodule

### rtl/vrt_queue.sv
// ----------------------------------------------------------------------------
// vrt_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module vrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vrt_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output vrt_pkg::item_t dout
);

  localparam int PW = (vrt_pkg::QUEUE_DEPTH > 1) ? $clog2(vrt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(vrt_pkg::QUEUE_DEPTH + 1);

  vrt_pkg::item_t slots [vrt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(vrt_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/vrt_back.sv
// ----------------------------------------------------------------------------
// vrt_back
// Occupancy store, ray setup through a shared multiplier, DDA walk,
// upper-half divider and result register.
// ----------------------------------------------------------------------------
module vrt_back #(
  parameter int GRID_SIZE = vrt_pkg::GRID_SIZE_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  vrt_pkg::item_t q_item,
  output logic           q_pop,
  output logic           clearing,
  vrt_res_if.source      res
);

  localparam int NVOX      = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int OCC_WORDS = (NVOX + 63) / 64;
  localparam int LIN_W     = $clog2(NVOX);
  localparam int WA_W      = LIN_W - 6;
  localparam int GC_W      = $clog2(GRID_SIZE);
  localparam int NUM_W     = $clog2(256 * (MAX_STEPS + 1) + 1);
  localparam int X_W       = NUM_W + 16;
  localparam int PM_W      = ($clog2(128 + MAX_STEPS + 1) > 9) ?
                             $clog2(128 + MAX_STEPS + 1) : 9;
  localparam int P_W       = PM_W + 1;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CMP_W     = (NUM_W > 16) ? NUM_W : 16;
  localparam int N_W       = NUM_W + 19;
  localparam int Q_W       = NUM_W + 10;
  localparam int QC_W      = $clog2(Q_W + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PROD = 4'd2;
  localparam logic [3:0] S_LA   = 4'd3;
  localparam logic [3:0] S_LB   = 4'd4;
  localparam logic [3:0] S_LC   = 4'd5;
  localparam logic [3:0] S_TB   = 4'd6;
  localparam logic [3:0] S_TC   = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_TEST = 4'd9;
  localparam logic [3:0] S_U1   = 4'd10;
  localparam logic [3:0] S_U2   = 4'd11;
  localparam logic [3:0] S_U3   = 4'd12;
  localparam logic [3:0] S_U4   = 4'd13;
  localparam logic [3:0] S_DIV  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state;

  // occupancy store
  logic [63:0]     occ [OCC_WORDS];
  logic [63:0]     rd;
  logic            we;
  logic [WA_W-1:0] wa;
  logic [63:0]     wd;
  logic [WA_W-1:0] ra;
  logic [WA_W-1:0] clr_addr;
  logic [31:0]     waddr32;
  logic            waddr_ok;

  // ray state
  logic signed [P_W-1:0] pos [3];
  logic [NUM_W-1:0]      num [3];
  logic [15:0]           mag [3];
  logic                  neg [3];
  logic                  zro [3];
  logic [15:0]           thr [3];
  logic signed [15:0]    oy;
  logic [15:0]           lim;
  logic [31:0]           d2;
  logic [63:0]           lsq;
  logic [15:0]           tval;
  logic [3:0]            bitn;
  logic [3:0]            cnt;
  logic [1:0]            ax;
  logic [X_W-1:0]        x01, x10, x02, x20, x12, x21;
  logic [STEP_W-1:0]     steps;
  logic [NUM_W-1:0]      entry;
  logic [2:0]            face;
  logic                  hitr;
  logic                  upr;
  logic                  ingrid_q;
  logic [5:0]            bit_q;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] prod;

  // upper-half divider
  logic signed [N_W-1:0] s1;
  logic signed [N_W-1:0] nsum;
  logic                  nneg;
  logic                  lownz;
  logic [Q_W-1:0]        ndiv;
  logic [15:0]           rem;
  logic [QC_W-1:0]       dcnt;
  logic [16:0]           r2;
  logic                  qbit;
  logic [15:0]           rem_n;
  logic [N_W-2:0]        nabs;

  // walk logic
  logic                  ingrid;
  logic [LIN_W-1:0]      lin;
  logic                  e01, e02, e12;
  logic [1:0]            sel;
  logic                  beyond;
  logic                  solid;
  logic [15:0]           cand_cur, tnext, cand_nxt;
  logic                  pop_w;

  // ---------------- store ----------------
  assign waddr32  = 32'(q_item.word_address);
  assign waddr_ok = (waddr32 < 32'(OCC_WORDS));
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign pop_w    = q_pop && (q_item.action == vrt_pkg::ACT_WRITE);
  assign clearing = (state == S_CLR);

  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    if (state == S_CLR) begin
      we = 1'b1;
    end else if (pop_w && waddr_ok) begin
      we = 1'b1;
      wa = waddr32[WA_W-1:0];
      wd = q_item.word_bits;
    end
  end

  always_comb begin
    ingrid = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (pos[k][P_W-1] || pos[k] >= $signed(P_W'(GRID_SIZE))) begin
        ingrid = 1'b0;
      end
    end
    lin = (LIN_W'(pos[2][GC_W-1:0]) * LIN_W'(GRID_SIZE) + LIN_W'(pos[1][GC_W-1:0]))
          * LIN_W'(GRID_SIZE) + LIN_W'(pos[0][GC_W-1:0]);
    ra  = lin[LIN_W-1:6];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      occ[wa] <= wd;
    end
    rd <= occ[ra];
  end

  // ---------------- multiplier ----------------
  assign cand_cur = tval | (16'd1 << bitn);
  assign tnext    = (prod <= lsq) ? cand_cur : tval;
  assign cand_nxt = tnext | (16'd1 << (bitn - 4'd1));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_PROD: begin
        case (cnt)
          4'd0: begin ma = 32'(mag[0]); mb = 32'(mag[0]); end
          4'd1: begin ma = 32'(mag[1]); mb = 32'(mag[1]); end
          4'd2: begin ma = 32'(mag[2]); mb = 32'(mag[2]); end
          4'd3: begin ma = 32'(num[0]); mb = 32'(mag[1]); end
          4'd4: begin ma = 32'(num[1]); mb = 32'(mag[0]); end
          4'd5: begin ma = 32'(num[0]); mb = 32'(mag[2]); end
          4'd6: begin ma = 32'(num[2]); mb = 32'(mag[0]); end
          4'd7: begin ma = 32'(num[1]); mb = 32'(mag[2]); end
          4'd8: begin ma = 32'(num[2]); mb = 32'(mag[1]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      S_LA: begin ma = 32'(lim); mb = 32'(mag[ax]); end
      S_LB: begin ma = prod[31:0]; mb = prod[31:0]; end
      S_LC: begin ma = 32'h0000_8000; mb = 32'h0000_8000; end
      S_TB: begin ma = prod[31:0]; mb = d2; end
      S_TC: begin ma = 32'(cand_nxt); mb = 32'(cand_nxt); end
      // |oy| zero-extended; -32768 gives 0x8000
      S_U1: begin ma = {16'd0, oy[15] ? 16'(-oy) : oy}; mb = 32'(mag[0]); end
      S_U2: begin ma = 32'(entry); mb = 32'(mag[1]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  // ---------------- walk decisions ----------------
  assign e01 = !zro[0] && (zro[1] || x01 < x10);
  assign e02 = !zro[0] && (zro[2] || x02 < x20);
  assign e12 = !zro[1] && (zro[2] || x12 < x21);
  assign sel = e01 ? (e02 ? 2'd0 : 2'd2) : (e12 ? 2'd1 : 2'd2);
  assign beyond = zro[sel] || (CMP_W'(num[sel]) > CMP_W'(thr[sel]));
  assign solid  = ingrid_q && rd[bit_q];

  // ---------------- divider step ----------------
  assign r2    = {rem, ndiv[Q_W-1]};
  assign qbit  = (r2 >= 17'(mag[0]));
  assign rem_n = qbit ? 16'(r2 - 17'(mag[0])) : r2[15:0];
  assign nabs  = nsum[N_W-1] ? (N_W-1)'(-nsum) : nsum[N_W-2:0];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WA_W'(OCC_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && q_item.action == vrt_pkg::ACT_FIRE) begin
            for (int k = 0; k < 3; k++) begin
              pos[k] <= P_W'($signed(q_item.ax[k].base));
              num[k] <= NUM_W'(q_item.ax[k].num);
              mag[k] <= q_item.ax[k].mag;
              neg[k] <= q_item.ax[k].neg;
              zro[k] <= q_item.ax[k].zero;
            end
            oy    <= q_item.origin_y;
            lim   <= q_item.ray_limit;
            d2    <= '0;
            cnt   <= '0;
            steps <= '0;
            entry <= '0;
            face  <= vrt_pkg::FACE_START;
            upr   <= 1'b0;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd1, 4'd2, 4'd3: d2 <= d2 + prod[31:0];
            4'd4: x01 <= X_W'(prod);
            4'd5: x10 <= X_W'(prod);
            4'd6: x02 <= X_W'(prod);
            4'd7: x20 <= X_W'(prod);
            4'd8: x12 <= X_W'(prod);
            4'd9: x21 <= X_W'(prod);
            default: ;
          endcase
          if (cnt == 4'd9) begin
            ax    <= 2'd0;
            state <= S_LA;
          end
        end
        S_LA: state <= S_LB;
        S_LB: state <= S_LC;
        S_LC: begin
          lsq   <= prod;
          tval  <= '0;
          bitn  <= 4'd15;
          state <= S_TB;
        end
        S_TB: state <= S_TC;
        S_TC: begin
          // keep the candidate bit when t^2 * d2 <= (lim * mag)^2
          tval <= tnext;
          if (bitn == 4'd0) begin
            thr[ax] <= tnext;
            if (ax == 2'd2) begin
              state <= S_RD;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_LA;
            end
          end else begin
            bitn  <= bitn - 4'd1;
            state <= S_TB;
          end
        end
        S_RD: begin
          ingrid_q <= ingrid;
          bit_q    <= lin[5:0];
          state    <= S_TEST;
        end
        S_TEST: begin
          if (solid) begin
            hitr  <= 1'b1;
            state <= (face == vrt_pkg::FACE_POS_X) ? S_U1 : S_OUT;
          end else if (beyond || steps >= STEP_W'(MAX_STEPS)) begin
            hitr  <= 1'b0;
            state <= S_OUT;
          end else begin
            entry     <= num[sel];
            num[sel]  <= num[sel] + NUM_W'(256);
            pos[sel]  <= neg[sel] ? pos[sel] - 1'b1 : pos[sel] + 1'b1;
            steps     <= steps + 1'b1;
            case (sel)
              2'd0: begin
                face <= neg[0] ? vrt_pkg::FACE_POS_X : vrt_pkg::FACE_NEG_X;
                x01  <= x01 + (X_W'(mag[1]) << 8);
                x02  <= x02 + (X_W'(mag[2]) << 8);
              end
              2'd1: begin
                face <= neg[1] ? vrt_pkg::FACE_POS_Y : vrt_pkg::FACE_NEG_Y;
                x10  <= x10 + (X_W'(mag[0]) << 8);
                x12  <= x12 + (X_W'(mag[2]) << 8);
              end
              default: begin
                face <= neg[2] ? vrt_pkg::FACE_POS_Z : vrt_pkg::FACE_NEG_Z;
                x20  <= x20 + (X_W'(mag[0]) << 8);
                x21  <= x21 + (X_W'(mag[1]) << 8);
              end
            endcase
            state <= S_RD;
          end
        end
        S_U1: state <= S_U2;
        S_U2: begin
          // 2 * oy * |dx|
          s1    <= oy[15] ? -(N_W'(prod[31:0]) <<< 1) : (N_W'(prod[31:0]) <<< 1);
          state <= S_U3;
        end
        S_U3: begin
          // + 2 * entry * dy
          nsum  <= neg[1] ? s1 - (N_W'(prod[X_W-1:0]) <<< 1) :
                            s1 + (N_W'(prod[X_W-1:0]) <<< 1);
          state <= S_U4;
        end
        S_U4: begin
          // floor(|n| / (|dx| * 256)) as floor((|n| >> 8) / |dx|)
          nneg  <= nsum[N_W-1];
          lownz <= (nabs[7:0] != 8'd0);
          ndiv  <= nabs[N_W-2:8];
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_n;
          ndiv <= {ndiv[Q_W-2:0], qbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == QC_W'(Q_W - 1)) begin
            upr   <= qbit ^ (nneg && (lownz || rem_n != 16'd0));
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res.valid) begin
            res.valid      <= 1'b1;
            res.hit        <= hitr;
            res.voxel_x    <= hitr ? pos[0][5:0] : 6'd0;
            res.voxel_y    <= hitr ? pos[1][5:0] : 6'd0;
            res.voxel_z    <= hitr ? pos[2][5:0] : 6'd0;
            res.entry_face <= hitr ? face : vrt_pkg::FACE_START;
            res.upper_half <= hitr && upr;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Occupancy grid with 3D DDA ray walk; write words load the grid, fire
// words return one hit/miss result word.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   action, word_address, word_bits, origin, dir,
//                               ray_limit
//   res      out  valid/ready   hit, voxel_x/y/z, entry_face, upper_half
//
// A write word is stored as it is popped from the queue. A ray first forms
// its products, then runs a threshold search per axis on the shared
// multiplier, then walks the voxels with one store read each, and on a +x
// face hit runs the upper-half divide; no new word is popped until it is done.
// After reset the store is cleared one word per cycle, all GRID_SIZE^3/64
// words (4096 by default), with cmd.ready low. A two-word queue and the
// result register let cmd and res stall independently.
module voxel_ray_traversal #(
  parameter int GRID_SIZE = vrt_pkg::GRID_SIZE_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input logic       clk,
  input logic       rst,
  vrt_cmd_if.sink   cmd,
  vrt_res_if.source res
);

  vrt_pkg::item_t f_item;
  vrt_pkg::item_t q_item;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;

  vrt_front u_front (
    .cmd      (cmd),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  vrt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  vrt_back #(
    .GRID_SIZE (GRID_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res)
  );

endmodule

### bench/voxel_ray_traversal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_tb
// Loads occupancy words and casts rays through the grid walker. A local DDA
// tracer predicts each hit/miss word; results are checked in order while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_tb;

  localparam int GRID     = 64;
  localparam int STEP_CAP = 256;
  localparam int WORDS    = GRID * GRID * GRID / 64;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic               action;
    logic [11:0]        word_address;
    logic [63:0]        word_bits;
    logic signed [15:0] org [3];
    logic signed [15:0] dir [3];
    logic [15:0]        ray_limit;
  } cmd_word_t;

  typedef struct {
    logic       hit;
    logic [5:0] vox [3];
    logic [2:0] face;
    logic       upper;
  } hit_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrt_cmd_if cmd ();
  vrt_res_if res ();

  voxel_ray_traversal dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [63:0] occ_map [WORDS];
  cmd_word_t   pending_cmds [$];
  hit_word_t   expected_hits [$];
  cmd_word_t   cur;
  int          send_pct, recv_pct;
  int          errors, n_writes, n_rays, n_hits, n_checked;
  int          hold_kick, hold_seen, hold_left;
  int          idle_cycles;

  function automatic bit sooner(longint unsigned na, longint unsigned ma, bit za,
                                longint unsigned nb, longint unsigned mb, bit zb);
    if (za) return 1'b0;
    if (zb) return 1'b1;
    return na * mb < nb * ma;
  endfunction

  function automatic bit is_solid(int px, int py, int pz);
    int lin;
    if (px < 0 || px >= GRID || py < 0 || py >= GRID || pz < 0 || pz >= GRID)
      return 1'b0;
    lin = (pz * GRID + py) * GRID + px;
    return occ_map[lin >> 6][lin & 63];
  endfunction

  // exact DDA walk; crossing times kept as num/|d| ratios
  function automatic hit_word_t trace_ray(cmd_word_t c);
    hit_word_t       r;
    int              p [3], o [3], d [3], st [3];
    longint unsigned n [3], m [3];
    bit              zr [3];
    longint unsigned lim, d2, entry;
    int              frac, steps, a, face, last;
    bit              found;
    longint          sn, den, q;
    lim = c.ray_limit; d2 = 0; entry = 0; steps = 0; face = 0; last = -1;
    found = 1'b0;
    for (int k = 0; k < 3; k++) begin
      o[k] = c.org[k];
      d[k] = c.dir[k];
      frac = o[k] & 255;
      p[k] = (o[k] - frac) / 256;
      st[k] = d[k] > 0 ? 1 : (d[k] < 0 ? -1 : 0);
      m[k] = d[k] < 0 ? -d[k] : d[k];
      zr[k] = d[k] == 0;
      n[k] = d[k] > 0 ? 256 - frac : frac;
      d2 += m[k] * m[k];
    end
    forever begin
      if (is_solid(p[0], p[1], p[2])) begin
        found = 1'b1;
        break;
      end
      if (sooner(n[0], m[0], zr[0], n[1], m[1], zr[1]))
        a = sooner(n[0], m[0], zr[0], n[2], m[2], zr[2]) ? 0 : 2;
      else
        a = sooner(n[1], m[1], zr[1], n[2], m[2], zr[2]) ? 1 : 2;
      if (zr[a] || n[a] > lim || n[a] * n[a] * d2 > lim * lim * m[a] * m[a] ||
          steps >= STEP_CAP)
        break;
      entry = n[a];
      p[a] += st[a];
      n[a] += 256;
      steps++;
      last = a;
      face = 1 + 2 * a + (st[a] > 0 ? 1 : 0);
    end
    r.hit = found;
    r.face = found ? face[2:0] : vrt_pkg::FACE_START;
    r.upper = 1'b0;
    for (int k = 0; k < 3; k++) r.vox[k] = found ? p[k][5:0] : 6'd0;
    if (found && r.face == vrt_pkg::FACE_POS_X && last == 0) begin
      den = longint'(m[0]) * 256;
      sn = 2 * longint'(o[1]) * longint'(m[0]) + 2 * longint'(entry) * longint'(d[1]);
      q = sn / den;
      if (sn % den != 0 && sn < 0) q--;
      r.upper = q[0];
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (cur.action == vrt_pkg::ACT_WRITE) begin
          occ_map[cur.word_address] = cur.word_bits;
          n_writes++;
        end else begin
          expected_hits.push_back(trace_ray(cur));
          n_rays++;
        end
      end
      if (!cmd.valid || cmd.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_pct) begin
          cur = pending_cmds.pop_front();
          cmd.action       <= cur.action;
          cmd.word_address <= cur.word_address;
          cmd.word_bits    <= cur.word_bits;
          cmd.origin_x     <= cur.org[0];
          cmd.origin_y     <= cur.org[1];
          cmd.origin_z     <= cur.org[2];
          cmd.dir_x        <= cur.dir[0];
          cmd.dir_y        <= cur.dir[1];
          cmd.dir_z        <= cur.dir[2];
          cmd.ray_limit    <= cur.ray_limit;
          cmd.valid        <= 1'b1;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    hit_word_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = expected_hits.pop_front();
          check_field("hit", want.hit, res.hit);
          check_field("voxel_x", want.vox[0], res.voxel_x);
          check_field("voxel_y", want.vox[1], res.voxel_y);
          check_field("voxel_z", want.vox[2], res.voxel_z);
          check_field("entry_face", want.face, res.entry_face);
          check_field("upper_half", want.upper, res.upper_half);
          if (want.hit) n_hits++;
          n_checked++;
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= $urandom_range(99) >= recv_pct;
      end
    end
  end

  // watchdog: stalls only count while work is outstanding
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready) ||
        (pending_cmds.size() == 0 && expected_hits.size() == 0 && !cmd.valid)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG) begin
      $display("Watchdog expired, no handshake for %0d cycles", WATCHDOG);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_word_t mk_write(int addr, logic [63:0] bits);
    cmd_word_t c;
    c.action = vrt_pkg::ACT_WRITE;
    c.word_address = 12'(addr);
    c.word_bits = bits;
    c.ray_limit = 16'($urandom);
    for (int k = 0; k < 3; k++) begin
      c.org[k] = 16'($urandom);
      c.dir[k] = 16'($urandom);
    end
    return c;
  endfunction

  function automatic cmd_word_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int span);
    cmd_word_t c;
    c.action = vrt_pkg::ACT_FIRE;
    c.word_address = 12'($urandom);
    c.word_bits = {$urandom, $urandom};
    c.org[0] = 16'(ox); c.org[1] = 16'(oy); c.org[2] = 16'(oz);
    c.dir[0] = 16'(dx); c.dir[1] = 16'(dy); c.dir[2] = 16'(dz);
    c.ray_limit = 16'(span);
    return c;
  endfunction

  // mostly rays and writes inside a dense 64x16x16 corner block so walks find solids
  task automatic push_random(int count);
    int ext;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30) begin
        pending_cmds.push_back(mk_write($urandom_range(99) < 85 ?
            $urandom_range(15) * 64 + $urandom_range(15) : $urandom_range(WORDS - 1),
            {$urandom, $urandom} & {$urandom, $urandom}));
      end else if ($urandom_range(99) < 80) begin
        ext = 16 * 256;
        pending_cmds.push_back(mk_ray($urandom_range(ext + 512) - 512,
            $urandom_range(ext + 512) - 512, $urandom_range(ext + 512) - 512,
            $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
            $urandom_range(ext)));
      end else begin
        pending_cmds.push_back(mk_ray($signed(16'($urandom)), $signed(16'($urandom)),
            $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
            $signed(16'($urandom)), $urandom_range(65535)));
      end
    end
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || cmd.valid || expected_hits.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    cmd.valid = 1'b0; cmd.action = vrt_pkg::ACT_WRITE; cmd.word_address = '0;
    cmd.word_bits = '0;
    cmd.origin_x = '0; cmd.origin_y = '0; cmd.origin_z = '0;
    cmd.dir_x = '0; cmd.dir_y = '0; cmd.dir_z = '0; cmd.ray_limit = '0;
    res.ready = 1'b0;
    errors = 0; n_writes = 0; n_rays = 0; n_hits = 0; n_checked = 0;
    hold_kick = 0; hold_seen = 0; hold_left = 0; idle_cycles = 0;
    send_pct = 7; recv_pct = 79;
    for (int i = 0; i < WORDS; i++) occ_map[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: grid corners, each face, zero direction, limits
    pending_cmds.push_back(mk_ray(5 * 256, 0, 0, 16384, 0, 0, 65535));   // empty grid
    pending_cmds.push_back(mk_write(0, '1));                            // row y0 z0
    pending_cmds.push_back(mk_write(WORDS - 1, '1));                    // row y63 z63
    pending_cmds.push_back(mk_write(3 * 64 + 9, 64'h8000_0000_0000_0001));
    pending_cmds.push_back(mk_ray(5 * 256 + 77, 100, 30, 0, 0, 0, 0));  // start voxel
    pending_cmds.push_back(mk_ray(5 * 256, 5 * 256, 5 * 256, 0, 0, 0, 65535));
    pending_cmds.push_back(mk_ray(-640, 192, 30, 16384, 0, 0, 4096));
    pending_cmds.push_back(mk_ray(70 * 256, 192, 30, -16384, 100, 0, 4096));  // upper
    pending_cmds.push_back(mk_ray(70 * 256, 64, 30, -16384, -50, 0, 4096));   // lower
    pending_cmds.push_back(mk_ray(3 * 256, -768, 20, 0, 16384, 0, 4096));
    pending_cmds.push_back(mk_ray(10 * 256, 66 * 256, 63 * 256 + 9, 0, -16384, 0, 4096));
    pending_cmds.push_back(mk_ray(0, 9 * 256 + 5, 5 * 256, 0, 0, -16384, 4096));
    pending_cmds.push_back(mk_ray(63 * 256, 3 * 256, 0, 0, 0, 16384, 65535));
    pending_cmds.push_back(mk_ray(-128, 10, 10, 16384, 0, 0, 0));       // zero distance
    pending_cmds.push_back(mk_ray(-32768, 20 * 256, 20 * 256, 16384, 0, 0, 65535));
    pending_cmds.push_back(mk_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535));
    pending_cmds.push_back(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
    pending_cmds.push_back(mk_ray(70 * 256, 70 * 256, 70 * 256, -9000, -9000, -9000,
                                  65535));
    pending_cmds.push_back(mk_ray(-256, -256, 0, 16384, 16384, 0, 2048));     // corner tie
    pending_cmds.push_back(mk_ray(256, 0, 0, 1, 0, 0, 65535));               // tiny dir
    drain();

    push_random(160);
    drain();

    send_pct = 79; recv_pct = 7;
    push_random(160);
    hold_kick++;
    drain();

    send_pct = 0; recv_pct = 0;
    push_random(160);
    drain();

    repeat (800) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $error("%0d result words never arrived", expected_hits.size());
      errors++;
    end
    $display("Covered %0d occupancy writes and %0d rays, %0d of them hits,", n_writes,
             n_rays, n_hits);
    $display("across three idle/stall mixes with one long receiver hold-off.");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
